// ===== hw/rtl/htfcc_pkg.sv =====
package htfcc_pkg;

    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [7:0]  CRC_POLY    = 8'h31;

    // full-scale factors for the raw / 65535 conversion, in hundredths
    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [15:0] TEMP_OFFSET = 16'd4500;

    localparam int TPROD_W = 31;   // 17500 * 65535 < 2**31
    localparam int HPROD_W = 30;   // 10000 * 65535 < 2**30

    typedef enum logic [2:0] {
        POS_T_MSB = 3'd0,
        POS_T_LSB = 3'd1,
        POS_T_CRC = 3'd2,
        POS_H_MSB = 3'd3,
        POS_H_LSB = 3'd4,
        POS_H_CRC = 3'd5
    } t_byte_pos;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_in_word;

    typedef struct packed {
        logic signed [14:0] temp_centi;
        logic [13:0]        hum_centi;
        logic               frame_ok;
        logic               temp_crc_ok;
        logic               hum_crc_ok;
    } t_out_word;

    typedef struct packed {
        logic temp_ok;
        logic hum_ok;
    } t_crc_flags;

    // completed frame handed from the byte tracker to the converter
    typedef struct packed {
        logic [15:0] raw_temp;
        logic [15:0] raw_hum;
        t_crc_flags  flags;
    } t_frame_rec;

    // CRC-8, MSB first, no reflection, no final xor
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7]) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/htfcc_frame.sv =====
module htfcc_frame (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  htfcc_pkg::t_in_word    i_word,
    output logic                   o_rec_valid,
    output htfcc_pkg::t_frame_rec  o_rec
);

    htfcc_pkg::t_byte_pos r_pos, n_pos, eff_pos;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_raw_temp, n_raw_temp;
    logic [15:0] r_raw_hum, n_raw_hum;
    logic        r_temp_ok, n_temp_ok;
    logic        hum_ok;
    logic        last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= htfcc_pkg::POS_T_MSB;
            r_crc      <= htfcc_pkg::CRC_INIT;
            r_raw_temp <= '0;
            r_raw_hum  <= '0;
            r_temp_ok  <= 1'b0;
        end else if (i_accept) begin
            r_pos      <= n_pos;
            r_crc      <= n_crc;
            r_raw_temp <= n_raw_temp;
            r_raw_hum  <= n_raw_hum;
            r_temp_ok  <= n_temp_ok;
        end
    end

    always_comb begin
        // frame start throws away any partial frame
        eff_pos    = i_word.frame_start ? htfcc_pkg::POS_T_MSB : r_pos;
        n_pos      = r_pos;
        n_crc      = r_crc;
        n_raw_temp = r_raw_temp;
        n_raw_hum  = r_raw_hum;
        n_temp_ok  = r_temp_ok;
        last_byte  = 1'b0;
        unique case (eff_pos)
            htfcc_pkg::POS_T_MSB: begin
                n_crc      = htfcc_pkg::crc8_feed(htfcc_pkg::CRC_INIT, i_word.rx_byte);
                n_raw_temp = {i_word.rx_byte, 8'h00};
                n_pos      = htfcc_pkg::POS_T_LSB;
            end
            htfcc_pkg::POS_T_LSB: begin
                n_crc      = htfcc_pkg::crc8_feed(r_crc, i_word.rx_byte);
                n_raw_temp = {r_raw_temp[15:8], i_word.rx_byte};
                n_pos      = htfcc_pkg::POS_T_CRC;
            end
            htfcc_pkg::POS_T_CRC: begin
                n_temp_ok  = (r_crc == i_word.rx_byte);
                n_crc      = htfcc_pkg::CRC_INIT;
                n_pos      = htfcc_pkg::POS_H_MSB;
            end
            htfcc_pkg::POS_H_MSB: begin
                n_crc      = htfcc_pkg::crc8_feed(htfcc_pkg::CRC_INIT, i_word.rx_byte);
                n_raw_hum  = {i_word.rx_byte, 8'h00};
                n_pos      = htfcc_pkg::POS_H_LSB;
            end
            htfcc_pkg::POS_H_LSB: begin
                n_crc      = htfcc_pkg::crc8_feed(r_crc, i_word.rx_byte);
                n_raw_hum  = {r_raw_hum[15:8], i_word.rx_byte};
                n_pos      = htfcc_pkg::POS_H_CRC;
            end
            htfcc_pkg::POS_H_CRC: begin
                n_crc      = htfcc_pkg::CRC_INIT;
                n_pos      = htfcc_pkg::POS_T_MSB;
                last_byte  = 1'b1;
            end
            default: begin
                // unused codes behave as the first slot
                n_crc      = htfcc_pkg::crc8_feed(htfcc_pkg::CRC_INIT, i_word.rx_byte);
                n_raw_temp = {i_word.rx_byte, 8'h00};
                n_pos      = htfcc_pkg::POS_T_LSB;
            end
        endcase
    end

    assign hum_ok      = (r_crc == i_word.rx_byte);
    assign o_rec_valid = i_accept && last_byte;

    always_comb begin
        o_rec.raw_temp      = r_raw_temp;
        o_rec.raw_hum       = r_raw_hum;
        o_rec.flags.temp_ok = r_temp_ok;
        o_rec.flags.hum_ok  = hum_ok;
    end

endmodule

// ===== hw/rtl/htfcc_convert.sv =====
module htfcc_convert (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_rec_valid,
    input  htfcc_pkg::t_frame_rec  i_rec,
    output logic                   o_rec_ready,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output htfcc_pkg::t_out_word   o_out_data
);

    // stage 1: captured frame
    logic                  r_v1;
    htfcc_pkg::t_frame_rec r_rec;
    // stage 2: products
    logic                             r_v2;
    logic [htfcc_pkg::TPROD_W-1:0]    r_tprod;
    logic [htfcc_pkg::HPROD_W-1:0]    r_hprod;
    htfcc_pkg::t_crc_flags            r_flags2;
    // stage 3: quotients by 65535
    logic                  r_v3;
    logic [14:0]           r_tq;
    logic [13:0]           r_hq;
    htfcc_pkg::t_crc_flags r_flags3;
    // stage 4: output word, whose values double as the stored readings
    logic                  r_v4;
    htfcc_pkg::t_out_word  r_out;

    logic        ld2, ld3, ld4;
    logic        free1, free2, free3;
    logic [31:0] t_sum, h_sum;
    logic [15:0] temp_wide;
    logic        all_ok;

    assign ld4   = r_v3 && (!r_v4 || i_out_ready);
    assign free3 = !r_v3 || ld4;
    assign ld3   = r_v2 && free3;
    assign free2 = !r_v2 || ld3;
    assign ld2   = r_v1 && free2;
    assign free1 = !r_v1 || ld2;

    assign o_rec_ready = free1;
    assign o_out_valid = r_v4;
    assign o_out_data  = r_out;

    // floor(x / 65535) = (x + (x >> 16) + 1) >> 16 while the quotient fits 16 bits
    assign t_sum = 32'(r_tprod) + 32'(r_tprod >> 16) + 32'd1;
    assign h_sum = 32'(r_hprod) + 32'(r_hprod >> 16) + 32'd1;

    assign temp_wide = {1'b0, r_tq} - htfcc_pkg::TEMP_OFFSET;
    assign all_ok    = r_flags3.temp_ok && r_flags3.hum_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (free1) begin
                r_v1 <= i_rec_valid;
            end
            if (free2) begin
                r_v2 <= r_v1;
            end
            if (free3) begin
                r_v3 <= r_v2;
            end
            if (ld4) begin
                r_v4 <= 1'b1;
            end else if (i_out_ready) begin
                r_v4 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (free1 && i_rec_valid) begin
            r_rec <= i_rec;
        end
        if (ld2) begin
            r_tprod  <= htfcc_pkg::TPROD_W'(r_rec.raw_temp)
                        * htfcc_pkg::TPROD_W'(htfcc_pkg::TEMP_SCALE);
            r_hprod  <= htfcc_pkg::HPROD_W'(r_rec.raw_hum)
                        * htfcc_pkg::HPROD_W'(htfcc_pkg::HUM_SCALE);
            r_flags2 <= r_rec.flags;
        end
        if (ld3) begin
            r_tq     <= t_sum[30:16];
            r_hq     <= h_sum[29:16];
            r_flags3 <= r_flags2;
        end
    end

    // stored readings reset to zero, so this register takes a reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out <= '0;
        end else if (ld4) begin
            if (all_ok) begin
                r_out.temp_centi <= $signed(temp_wide[14:0]);
                r_out.hum_centi  <= r_hq;
            end
            r_out.frame_ok    <= all_ok;
            r_out.temp_crc_ok <= r_flags3.temp_ok;
            r_out.hum_crc_ok  <= r_flags3.hum_ok;
        end
    end

endmodule

// ===== hw/rtl/humidity_temp_frame_check_convert_top.sv =====
// Measurement frame checker for a temperature/humidity sensor. Feed the six frame bytes one
// word at a time (temperature MSB, LSB, CRC, humidity MSB, LSB, CRC); frame_start resyncs the
// byte slot. Each 16-bit word is checked with CRC-8 (poly 0x31, init 0xFF). After the sixth
// byte one result word comes out: on a good frame the converted readings in hundredths
// (deg C from -45.00, %RH), otherwise the last good readings (zero after reset) with
// frame_ok low. One byte is taken every cycle while o_in_ready is high; the limit is
// the CRC update of the byte tracker. The sixth byte's record is captured at the edge
// that takes it, then passes a constant-multiply stage and a divide-by-65535 correction
// stage to the output register. Input is taken while a result waits, until the stages fill.
module humidity_temp_frame_check_convert_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  htfcc_pkg::t_in_word   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output htfcc_pkg::t_out_word  o_out_data
);

    logic                  accept;
    logic                  rec_valid;
    logic                  rec_ready;
    htfcc_pkg::t_frame_rec rec;

    assign o_in_ready = rec_ready;
    assign accept     = i_in_valid && rec_ready;

    htfcc_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_word      (i_in_data),
        .o_rec_valid (rec_valid),
        .o_rec       (rec)
    );

    htfcc_convert u_convert (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (rec_valid),
        .i_rec       (rec),
        .o_rec_ready (rec_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
